### rtl/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  // Internal angle and series values carry 29 fractional bits.
  localparam int QB = 29;

  // Magnitude width of a reduced angle (at most pi).
  localparam int XW = 31;
  // Width of the full-turn constant.
  localparam int TW = 32;

  localparam logic [XW-1:0] Q_PI      = 31'd1686629713;
  localparam logic [XW-1:0] Q_HALF_PI = 31'd843314857;
  localparam logic [TW-1:0] Q_TWO_PI  = 32'd3373259426;

  // Reciprocal of a full turn, used to estimate how many whole turns an
  // angle holds. The angle magnitude is shifted down by RCP_IN_SH before the
  // multiply and the product is shifted down by RCP_OUT_SH after it.
  localparam int RCP_IN_SH  = 16;
  localparam int RCP_OUT_SH = 36;
  localparam int RCPW       = 21;
  localparam logic [RCPW-1:0] Q_TWO_PI_RCP =
    RCPW'((64'd1 << (RCP_IN_SH + RCP_OUT_SH)) / 64'(Q_TWO_PI));

  // Series coefficients 1/3!, 1/5!, 1/7!, 1/9!.
  localparam logic [26:0] Q_C3 = 27'd89478485;
  localparam logic [22:0] Q_C5 = 23'd4473924;
  localparam logic [16:0] Q_C7 = 17'd106522;
  localparam logic [10:0] Q_C9 = 11'd1479;

  // Widths of the even powers and of the series terms.
  localparam int X2W  = 33;
  localparam int X4W  = 36;
  localparam int X6W  = 39;
  localparam int X8W  = 43;
  localparam int T3W  = 31;
  localparam int T5W  = 30;
  localparam int T7W  = 27;
  localparam int T9W  = 25;
  localparam int SUMW = 33;
  localparam int VW   = 32;

  localparam logic signed [SUMW-1:0] Q_ONE = 33'sd536870912;

  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    FUNC_SIN = 2'd0,
    FUNC_COS = 2'd1,
    FUNC_TAN = 2'd2
  } func_t;

  typedef struct packed {
    logic  vld;
    func_t func;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/sct_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-stage unsigned multiply, result is the product shifted down by QB.
module sct_mul
  import sct_pkg::*;
#(
  parameter int AW = 31,
  parameter int BW = 31,
  parameter int OW = 33
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] p
);

  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AW+BL-1:0] pl_r;
  logic [AW+BH-1:0] ph_r;
  logic [PW-1:0]    sum_nxt;
  logic [OW-1:0]    p_r;

  assign sum_nxt = {ph_r, {BL{1'b0}}} + PW'(pl_r);

  always_ff @(posedge clk) begin
    pl_r <= a * b[BL-1:0];
    ph_r <= a * b[BW-1:BL];
    p_r  <= sum_nxt[QB+OW-1:QB];
  end

  assign p = p_r;

endmodule

`default_nettype wire

### rtl/sct_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

// Range reduction into [-pi, pi]. A reciprocal multiply
// estimates the whole turns in the magnitude (exact or one short), the turns
// are taken off, and one compare and subtract finishes the remainder.
module sct_reduce
  import sct_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter bit PHASE     = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               in_ctl,
  input  logic signed [31:0] in_ang,
  output ctl_t               out_ctl,
  output logic [XW-1:0]      out_mag,
  output logic               out_neg
);

  localparam int SH = QB - FRAC_BITS;
  localparam int WW = 33 + SH;
  localparam int MW = 32 + SH;
  localparam int HW = MW - RCP_IN_SH;
  localparam int EW = HW + RCPW;
  localparam int KW = EW - RCP_OUT_SH;
  localparam int PW = KW + TW;
  localparam int RW = TW + 2;
  localparam int ND = 7;

  logic signed [WW-1:0] w_nxt;
  logic signed [WW-1:0] w_r;
  logic [WW-1:0]        wneg;
  logic [MW-1:0]        mag_dl_r [0:2];
  logic                 neg_dl_r [0:4];
  logic [EW-1:0]        est_nxt;
  logic [KW-1:0]        turns_r;
  logic [PW-1:0]        prod_nxt;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        diff_nxt;
  logic [RW-1:0]        rc_r;
  logic                 rc_big;
  logic [RW-1:0]        rc_sub;
  logic [TW-1:0]        rem_r;
  ctl_t                 ctl_r [0:ND-1];
  logic                 fold_big;
  logic [TW-1:0]        fold_nxt;
  logic [XW-1:0]        mag_r;
  logic                 sgn_r;

  assign w_nxt    = (WW'(in_ang) <<< SH) + WW'(Q_HALF_PI & {XW{PHASE}});
  assign wneg     = -w_r;
  assign est_nxt  = EW'(mag_dl_r[0][MW-1:RCP_IN_SH]) * EW'(Q_TWO_PI_RCP);
  assign prod_nxt = PW'(turns_r) * PW'(Q_TWO_PI);
  assign diff_nxt = PW'(mag_dl_r[2]) - prod_r;
  assign rc_big   = rc_r >= RW'(Q_TWO_PI);
  assign rc_sub   = rc_r - RW'(Q_TWO_PI);
  assign fold_big = rem_r > TW'(Q_PI);
  assign fold_nxt = fold_big ? (Q_TWO_PI - rem_r) : rem_r;

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    neg_dl_r[0] <= w_r[WW-1];
    mag_dl_r[0] <= w_r[WW-1] ? wneg[MW-1:0] : w_r[MW-1:0];
    for (int k = 1; k < 5; k++) begin
      neg_dl_r[k] <= neg_dl_r[k-1];
    end
    mag_dl_r[1] <= mag_dl_r[0];
    mag_dl_r[2] <= mag_dl_r[1];
    turns_r     <= est_nxt[EW-1:RCP_OUT_SH];
    prod_r      <= prod_nxt;
    rc_r        <= diff_nxt[RW-1:0];
    rem_r       <= rc_big ? rc_sub[TW-1:0] : rc_r[TW-1:0];
    mag_r       <= fold_nxt[XW-1:0];
    sgn_r       <= fold_big ? ~neg_dl_r[4] : neg_dl_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ND; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < ND; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  assign out_ctl = ctl_r[ND-1];
  assign out_mag = mag_r;
  assign out_neg = sgn_r;

endmodule

`default_nettype wire

### rtl/sct_poly.sv
`timescale 1ns / 1ps
`default_nettype none

// Degree-9 odd sine series on a reduced angle.
module sct_poly
  import sct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 in_ctl,
  input  logic [XW-1:0]        in_mag,
  input  logic                 in_neg,
  output ctl_t                 out_ctl,
  output logic signed [VW-1:0] out_val
);

  logic [X2W-1:0]  x2;
  logic [X4W-1:0]  x4;
  logic [X6W-1:0]  x6;
  logic [X8W-1:0]  x8;
  logic [T3W-1:0]  t3;
  logic [T5W-1:0]  t5;
  logic [T7W-1:0]  t7;
  logic [T9W-1:0]  t9;
  logic [X2W-1:0]  x2_dl_r [0:3];
  logic [T3W-1:0]  t3_dl_r [0:5];
  logic [T5W-1:0]  t5_dl_r [0:3];
  logic [T7W-1:0]  t7_dl_r [0:1];
  logic [XW-1:0]   xm_dl_r [0:10];
  logic            xn_dl_r [0:12];
  logic            ss_dl_r [0:1];
  ctl_t            ctl_dl_r [0:13];
  logic signed [SUMW-1:0] s_nxt;
  logic signed [SUMW-1:0] s_r;
  logic [SUMW-1:0] s_neg;
  logic [31:0]     s_mag;
  logic [31:0]     v_mag;
  logic signed [VW-1:0] val_r;

  assign s_nxt = Q_ONE - SUMW'(t3_dl_r[5]) + SUMW'(t5_dl_r[3])
               - SUMW'(t7_dl_r[1]) + SUMW'(t9);
  assign s_neg = -s_r;
  assign s_mag = s_r[SUMW-1] ? s_neg[31:0] : s_r[31:0];

  sct_mul #(.AW(XW),  .BW(XW),  .OW(X2W)) u_x2 (.clk, .a(in_mag), .b(in_mag), .p(x2));
  sct_mul #(.AW(X2W), .BW(X2W), .OW(X4W)) u_x4 (.clk, .a(x2), .b(x2), .p(x4));
  sct_mul #(.AW(X2W), .BW(27),  .OW(T3W)) u_t3 (.clk, .a(x2), .b(Q_C3), .p(t3));
  sct_mul #(.AW(X4W), .BW(X2W), .OW(X6W)) u_x6 (.clk, .a(x4), .b(x2_dl_r[1]), .p(x6));
  sct_mul #(.AW(X4W), .BW(23),  .OW(T5W)) u_t5 (.clk, .a(x4), .b(Q_C5), .p(t5));
  sct_mul #(.AW(X6W), .BW(X2W), .OW(X8W)) u_x8 (.clk, .a(x6), .b(x2_dl_r[3]), .p(x8));
  sct_mul #(.AW(X6W), .BW(17),  .OW(T7W)) u_t7 (.clk, .a(x6), .b(Q_C7), .p(t7));
  sct_mul #(.AW(X8W), .BW(11),  .OW(T9W)) u_t9 (.clk, .a(x8), .b(Q_C9), .p(t9));
  sct_mul #(.AW(XW),  .BW(32),  .OW(32))  u_v  (.clk, .a(xm_dl_r[10]), .b(s_mag), .p(v_mag));

  always_ff @(posedge clk) begin
    x2_dl_r[0] <= x2;
    t3_dl_r[0] <= t3;
    t5_dl_r[0] <= t5;
    t7_dl_r[0] <= t7;
    xm_dl_r[0] <= in_mag;
    xn_dl_r[0] <= in_neg;
    ss_dl_r[0] <= s_r[SUMW-1];
    for (int k = 1; k < 4; k++)  x2_dl_r[k] <= x2_dl_r[k-1];
    for (int k = 1; k < 6; k++)  t3_dl_r[k] <= t3_dl_r[k-1];
    for (int k = 1; k < 4; k++)  t5_dl_r[k] <= t5_dl_r[k-1];
    t7_dl_r[1] <= t7_dl_r[0];
    for (int k = 1; k < 11; k++) xm_dl_r[k] <= xm_dl_r[k-1];
    for (int k = 1; k < 13; k++) xn_dl_r[k] <= xn_dl_r[k-1];
    ss_dl_r[1] <= ss_dl_r[0];
    s_r   <= s_nxt;
    val_r <= (xn_dl_r[12] ^ ss_dl_r[1]) ? -$signed(v_mag) : $signed(v_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 14; k++) begin
        ctl_dl_r[k] <= '0;
      end
    end else begin
      ctl_dl_r[0] <= in_ctl;
      for (int k = 1; k < 14; k++) begin
        ctl_dl_r[k] <= ctl_dl_r[k-1];
      end
    end
  end

  assign out_ctl = ctl_dl_r[13];
  assign out_val = val_r;

endmodule

`default_nettype wire

### rtl/sct_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Output stage: sine/cosine scaling and a one-bit-per-stage tangent divider.
module sct_div
  import sct_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 in_ctl,
  input  logic signed [VW-1:0] in_s,
  input  logic signed [VW-1:0] in_c,
  output logic                 out_vld,
  output logic signed [31:0]   out_value,
  output logic                 out_sat
);

  localparam int SH = QB - FRAC_BITS;
  localparam int DW = 30;
  localparam int QW = 32;
  localparam int CW = DW + QW;

  typedef struct packed {
    ctl_t          ctl;
    logic          neg;
    logic          czero;
    logic          sneg;
    logic          ovf;
    logic [VW-1:0] scv;
    logic [CW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] q;
  } dv_t;

  dv_t           st_r [0:QW+1];
  dv_t           st_nxt [1:QW+1];
  dv_t           prep_nxt;
  dv_t           fin;
  logic [VW-1:0] s_abs;
  logic [VW-1:0] c_abs;
  logic [VW-1:0] v_sel;
  logic [VW-1:0] v_abs;
  logic [VW-1:0] v_shr;
  logic [31:0]   val_nxt;
  logic          sat_nxt;
  logic          vld_r;
  logic [31:0]   val_r;
  logic          sat_r;

  always_comb begin
    s_abs = in_s[VW-1] ? -in_s : in_s;
    c_abs = in_c[VW-1] ? -in_c : in_c;
    v_sel = (in_ctl.func == FUNC_COS) ? in_c : in_s;
    v_abs = v_sel[VW-1] ? -v_sel : v_sel;
    v_shr = v_abs >> SH;
    prep_nxt.ctl   = in_ctl;
    prep_nxt.neg   = in_s[VW-1] ^ in_c[VW-1];
    prep_nxt.czero = (in_c == '0);
    prep_nxt.sneg  = in_s[VW-1];
    prep_nxt.ovf   = 1'b0;
    prep_nxt.scv   = v_sel[VW-1] ? -v_shr : v_shr;
    prep_nxt.rem   = CW'(s_abs[DW-1:0]) << FRAC_BITS;
    prep_nxt.den   = c_abs[DW-1:0];
    prep_nxt.q     = '0;
  end

  // The first stage flags a quotient too large for 32 bits; each later
  // stage settles one quotient bit, most significant first.
  always_comb begin
    st_nxt[1]     = st_r[0];
    st_nxt[1].ovf = st_r[0].rem >= (CW'(st_r[0].den) << QW);
    for (int k = 0; k < QW; k++) begin
      st_nxt[k+2] = st_r[k+1];
      if (st_r[k+1].rem >= (CW'(st_r[k+1].den) << (QW - 1 - k))) begin
        st_nxt[k+2].rem       = st_r[k+1].rem - (CW'(st_r[k+1].den) << (QW - 1 - k));
        st_nxt[k+2].q[QW-1-k] = 1'b1;
      end
    end
  end

  assign fin = st_r[QW+1];

  always_comb begin
    val_nxt = VAL_MAX;
    sat_nxt = 1'b0;
    case (fin.ctl.func) inside
      FUNC_SIN, FUNC_COS: begin
        val_nxt = fin.scv;
      end
      default: begin
        if (fin.czero) begin
          sat_nxt = 1'b1;
          val_nxt = fin.sneg ? VAL_MIN : VAL_MAX;
        end else if (fin.ovf || (!fin.neg && fin.q[QW-1]) ||
                     (fin.neg && (fin.q > VAL_MIN))) begin
          sat_nxt = 1'b1;
          val_nxt = fin.neg ? VAL_MIN : VAL_MAX;
        end else begin
          val_nxt = fin.neg ? -fin.q : fin.q;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW + 1; k++) begin
        st_r[k].ctl <= '0;
      end
      vld_r <= 1'b0;
      val_r <= '0;
      sat_r <= 1'b0;
    end else begin
      st_r[0] <= prep_nxt;
      for (int k = 1; k <= QW + 1; k++) begin
        st_r[k] <= st_nxt[k];
      end
      vld_r <= fin.ctl.vld;
      val_r <= val_nxt;
      // Empty slots carry leftover data; keep the flag low for them.
      sat_r <= sat_nxt & fin.ctl.vld;
    end
  end

  assign out_vld   = vld_r;
  assign out_value = val_r;
  assign out_sat   = sat_r;

endmodule

`default_nettype wire

### rtl/sine_cosine_tangent_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point sine, cosine and tangent. A word (function select and a signed
// angle in radians with FRAC_BITS fractional bits) is taken on any cycle with
// start high; busy is always low, so one word can enter every clock. Each
// result appears on out_value and out_saturated for exactly one cycle with
// out_valid high, in the order the words went in. The receiver cannot hold
// results off, and none is needed: nothing in the path ever waits. The depth
// comes from the seven-stage angle reduction (a reciprocal multiply estimates
// the whole turns, then one correction step), the registered multiplies of
// the 14-stage series, and the 35-stage tangent divider, which settles one
// quotient bit per stage.
module sine_cosine_tangent_unit
  import sct_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic               out_saturated
);

  ctl_t                 in_ctl;
  ctl_t                 red_ctl_s;
  ctl_t                 red_ctl_c;
  logic [XW-1:0]        red_mag_s;
  logic [XW-1:0]        red_mag_c;
  logic                 red_neg_s;
  logic                 red_neg_c;
  ctl_t                 poly_ctl_s;
  ctl_t                 poly_ctl_c;
  logic signed [VW-1:0] poly_s;
  logic signed [VW-1:0] poly_c;

  // The pipeline never stalls, so a word is accepted whenever start is high.
  assign busy        = 1'b0;
  assign in_ctl.vld  = start & ~busy;
  assign in_ctl.func = func_t'(in_func);

  // The sine lane works on the angle itself, the cosine lane on the angle
  // advanced by a quarter turn. Tangent uses both.
  sct_reduce #(.FRAC_BITS(FRAC_BITS), .PHASE(1'b0)) u_red_s (
    .clk, .rst_n, .in_ctl, .in_ang(in_angle),
    .out_ctl(red_ctl_s), .out_mag(red_mag_s), .out_neg(red_neg_s)
  );

  sct_reduce #(.FRAC_BITS(FRAC_BITS), .PHASE(1'b1)) u_red_c (
    .clk, .rst_n, .in_ctl, .in_ang(in_angle),
    .out_ctl(red_ctl_c), .out_mag(red_mag_c), .out_neg(red_neg_c)
  );

  sct_poly u_poly_s (
    .clk, .rst_n, .in_ctl(red_ctl_s), .in_mag(red_mag_s), .in_neg(red_neg_s),
    .out_ctl(poly_ctl_s), .out_val(poly_s)
  );

  sct_poly u_poly_c (
    .clk, .rst_n, .in_ctl(red_ctl_c), .in_mag(red_mag_c), .in_neg(red_neg_c),
    .out_ctl(poly_ctl_c), .out_val(poly_c)
  );

  // Final stage picks the lane result for sine and cosine, rescaled to FRAC_BITS,
  // and divides the two lanes for tangent with clamping at the signed 32-bit limits.
  sct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .in_ctl(poly_ctl_s), .in_s(poly_s), .in_c(poly_c),
    .out_vld(out_valid), .out_value, .out_sat(out_saturated)
  );

`ifndef SYNTH
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    poly_ctl_s == poly_ctl_c)
    else $error("sine and cosine lanes out of step");

  a_sat_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> out_valid)
    else $error("saturation flag without a result");

  a_sat_is_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> (out_value == VAL_MAX || out_value == VAL_MIN))
    else $error("saturated result is not a limit value");
`endif

endmodule

`default_nettype wire
